FILE: hw/rtl/pve_pkg.sv
// Shared types and constants for the program stream video payload extractor.
`default_nettype none

package pve_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FRAME_W     = 25;
    localparam int unsigned SEC_LEN_W   = 16;
    localparam int unsigned FIELD_CNT_W = 4;

    // Pack header is 14 bytes; the last one carries the stuffing count.
    localparam logic [FIELD_CNT_W-1:0] PACK_HDR_LAST  = 4'd13;
    localparam logic [2:0]             STUFF_MASK     = 3'h7;
    localparam logic [FIELD_CNT_W-1:0] CODE_LAST      = 4'd3;
    localparam logic [FIELD_CNT_W-1:0] LEN_LAST       = 4'd1;
    localparam logic [FIELD_CNT_W-1:0] FLAG_LAST      = 4'd2;

    localparam logic [23:0] START_PREFIX = 24'h000001;
    localparam logic [7:0]  SID_VIDEO    = 8'hE0;
    localparam logic [7:0]  SID_SYS_HDR  = 8'hBB;
    localparam logic [7:0]  SID_PSM      = 8'hBC;

    localparam logic [FRAME_W-1:0] MAX_FRAME_RESET = 25'd2097152;

    typedef enum logic [3:0] {
        PHASE_PACK     = 4'd0,
        PHASE_STUFF    = 4'd1,
        PHASE_CODE     = 4'd2,
        PHASE_PES_LEN  = 4'd3,
        PHASE_SKIP_LEN = 4'd4,
        PHASE_PES_FLAG = 4'd5,
        PHASE_PES_HDR  = 4'd6,
        PHASE_PAYLOAD  = 4'd7,
        PHASE_SKIP     = 4'd8,
        PHASE_HALT     = 4'd9
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  payload_byte;
        logic               byte_valid;
        logic               frame_done;
        logic [FRAME_W-1:0] frame_bytes;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pve_parser.sv
// Front end: start code walker that classifies each byte and tracks the frame count.
`default_nettype none

module pve_parser (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [pve_pkg::FRAME_W-1:0]  cfg_wdata,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [pve_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                         in_last,
    output logic                              push,
    output pve_pkg::result_t                  push_data
);
    import pve_pkg::*;

    phase_t                  phase_reg,  phase_next;
    logic [FIELD_CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [SEC_LEN_W-1:0]    len_reg,    len_next;
    logic [23:0]             shift_reg,  shift_next;
    logic [7:0]              skip_reg,   skip_next;
    logic [FRAME_W-1:0]      frame_reg,  frame_next;
    logic                    drop_reg,   drop_next;
    logic [FRAME_W-1:0]      max_reg;

    logic                    fire;
    logic                    emit;
    logic                    done;
    logic [SEC_LEN_W-1:0]    len_dec;
    logic [7:0]              skip_dec;
    logic [FIELD_CNT_W-1:0]  cnt_inc;
    logic [SEC_LEN_W-1:0]    plen;
    logic [FRAME_W:0]        plen_sum;
    logic                    over_limit;

    assign fire     = in_valid && in_ready;
    assign len_dec  = len_reg - 16'd1;
    assign skip_dec = skip_reg - 8'd1;
    assign cnt_inc  = cnt_reg + 4'd1;
    assign plen     = len_dec - {8'd0, in_byte};
    assign plen_sum = {{(FRAME_W+1-SEC_LEN_W){1'b0}}, plen} + {1'b0, frame_reg};
    assign over_limit = plen_sum >= {1'b0, max_reg};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        shift_next = shift_reg;
        skip_next  = skip_reg;
        frame_next = frame_reg;
        drop_next  = drop_reg;
        emit       = 1'b0;

        unique case (phase_reg)
            PHASE_PACK: begin
                cnt_next = cnt_inc;
                if (cnt_reg == PACK_HDR_LAST) begin
                    skip_next = {5'd0, in_byte[2:0] & STUFF_MASK};
                    if ((in_byte[2:0] & STUFF_MASK) == 3'd0) begin
                        phase_next = PHASE_CODE;
                        cnt_next   = '0;
                        shift_next = '0;
                    end else begin
                        phase_next = PHASE_STUFF;
                    end
                end
            end
            PHASE_STUFF: begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0) begin
                    phase_next = PHASE_CODE;
                    cnt_next   = '0;
                    shift_next = '0;
                end
            end
            PHASE_CODE: begin
                shift_next = {shift_reg[15:0], in_byte};
                cnt_next   = cnt_inc;
                if (cnt_reg == CODE_LAST) begin
                    cnt_next = '0;
                    len_next = '0;
                    if (shift_reg != START_PREFIX) begin
                        phase_next = PHASE_HALT;
                    end else if (in_byte == SID_VIDEO) begin
                        phase_next = PHASE_PES_LEN;
                    end else if (in_byte == SID_SYS_HDR || in_byte == SID_PSM) begin
                        phase_next = PHASE_SKIP_LEN;
                    end else begin
                        phase_next = PHASE_HALT;
                    end
                end
            end
            PHASE_PES_LEN, PHASE_SKIP_LEN: begin
                len_next = {len_reg[7:0], in_byte};
                cnt_next = cnt_inc;
                if (cnt_reg == LEN_LAST) begin
                    cnt_next = '0;
                    if ({len_reg[7:0], in_byte} == 16'd0) begin
                        phase_next = PHASE_CODE;
                        shift_next = '0;
                    end else if (phase_reg == PHASE_PES_LEN) begin
                        phase_next = PHASE_PES_FLAG;
                    end else begin
                        phase_next = PHASE_SKIP;
                    end
                end
            end
            PHASE_PES_FLAG: begin
                len_next = len_dec;
                cnt_next = cnt_inc;
                if (cnt_reg == FLAG_LAST) begin
                    // Third flag byte holds the header data length.
                    skip_next = in_byte;
                    drop_next = (len_dec > {8'd0, in_byte}) && over_limit;
                    if (len_dec == 16'd0) begin
                        phase_next = PHASE_CODE;
                        cnt_next   = '0;
                        shift_next = '0;
                    end else if (in_byte != 8'd0) begin
                        phase_next = PHASE_PES_HDR;
                    end else begin
                        phase_next = PHASE_PAYLOAD;
                    end
                end else if (len_dec == 16'd0) begin
                    phase_next = PHASE_CODE;
                    cnt_next   = '0;
                    shift_next = '0;
                end
            end
            PHASE_PES_HDR: begin
                len_next  = len_dec;
                skip_next = skip_dec;
                if (len_dec == 16'd0) begin
                    phase_next = PHASE_CODE;
                    cnt_next   = '0;
                    shift_next = '0;
                end else if (skip_dec == 8'd0) begin
                    phase_next = PHASE_PAYLOAD;
                end
            end
            PHASE_PAYLOAD: begin
                if (!drop_reg) begin
                    emit       = 1'b1;
                    frame_next = frame_reg + 25'd1;
                end
                len_next = len_dec;
                if (len_dec == 16'd0) begin
                    phase_next = PHASE_CODE;
                    cnt_next   = '0;
                    shift_next = '0;
                end
            end
            PHASE_SKIP: begin
                len_next = len_dec;
                if (len_dec == 16'd0) begin
                    phase_next = PHASE_CODE;
                    cnt_next   = '0;
                    shift_next = '0;
                end
            end
            PHASE_HALT: begin
            end
            default: begin
                phase_next = PHASE_HALT;
            end
        endcase
    end

    assign done = in_last && (frame_next != '0);
    assign push = fire && (emit || done);

    always_comb begin
        push_data.payload_byte = emit ? in_byte : '0;
        push_data.byte_valid   = emit;
        push_data.frame_done   = done;
        push_data.frame_bytes  = done ? frame_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_FRAME_RESET;
        end else if (cfg_we) begin
            max_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_PACK;
            cnt_reg   <= '0;
            len_reg   <= '0;
            shift_reg <= '0;
            skip_reg  <= '0;
            frame_reg <= '0;
            drop_reg  <= 1'b0;
        end else if (fire) begin
            if (in_last) begin
                // Pack ends: start over on the next pack header.
                phase_reg <= PHASE_PACK;
                cnt_reg   <= '0;
                len_reg   <= '0;
                shift_reg <= '0;
                skip_reg  <= '0;
                frame_reg <= '0;
                drop_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                len_reg   <= len_next;
                shift_reg <= shift_next;
                skip_reg  <= skip_next;
                frame_reg <= frame_next;
                drop_reg  <= drop_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pve_queue.sv
// Small result queue between the parser and the output stage.
`default_nettype none

module pve_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire pve_pkg::result_t  push_data,
    input  wire logic              pop,
    output pve_pkg::result_t       head_data,
    output pve_pkg::queue_status_t status
);
    import pve_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    result_t             mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_data    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pve_output.sv
// Back end: output register that drains the queue onto the result channel.
`default_nettype none

module pve_output (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pve_pkg::result_t              head_data,
    input  wire pve_pkg::queue_status_t        status,
    output logic                               pop,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic [pve_pkg::BYTE_W-1:0]         m_payload_byte,
    output logic                               m_byte_valid,
    output logic                               m_frame_done,
    output logic [pve_pkg::FRAME_W-1:0]        m_frame_bytes
);
    import pve_pkg::*;

    logic    valid_reg;
    result_t data_reg;
    logic    load;

    // Refill from a nonempty queue whenever the register is empty or its beat is taken this cycle.
    assign load = !status.empty && (!valid_reg || m_ready);
    assign pop  = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= head_data;
        end
    end

    assign m_valid        = valid_reg;
    assign m_payload_byte = data_reg.payload_byte;
    assign m_byte_valid   = data_reg.byte_valid;
    assign m_frame_done   = data_reg.frame_done;
    assign m_frame_bytes  = data_reg.frame_bytes;

endmodule

`default_nettype wire

FILE: hw/rtl/ps_video_payload_extractor_top.sv
// Program stream video payload extractor: byte-wide parser, result queue, output register.
//
// Input channel (s_): one program stream byte per beat, s_pack_end on the pack's last byte.
// Result channel (m_): one beat per emitted video payload byte and/or per pack end with a
//   nonzero frame length; m_frame_bytes is the pack's payload count on a frame_done beat.
// Config: cfg_we/cfg_wdata write the frame byte limit (reset 2097152); a PES whose payload
//   would bring the frame to or past the limit is consumed without output.
// Throughput: one byte per cycle while s_ready is high; the parser updates its state in the
//   accept cycle and bytes that produce no result leave nothing in the queue.
// Path: a result is written into the queue at the accept edge and loaded into the output
//   register once that register is empty or its beat is taken.
// Stall: results collect in a QUEUE_DEPTH-entry queue behind the output register; s_ready
//   drops only when the queue is full, so a stalled receiver holds the input side once
//   QUEUE_DEPTH + 1 results are waiting.
// Reset: synchronous, active low; parser returns to the pack header phase, queue and
//   output register empty, limit back to its default.
`default_nettype none

module ps_video_payload_extractor_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [pve_pkg::FRAME_W-1:0]   cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pve_pkg::BYTE_W-1:0]    s_stream_byte,
    input  wire logic                          s_pack_end,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [pve_pkg::BYTE_W-1:0]         m_payload_byte,
    output logic                               m_byte_valid,
    output logic                               m_frame_done,
    output logic [pve_pkg::FRAME_W-1:0]        m_frame_bytes
);
    import pve_pkg::*;

    logic          push;
    result_t       push_data;
    logic          pop;
    result_t       head_data;
    queue_status_t status;

    assign s_ready = !status.full;

    pve_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_byte   (s_stream_byte),
        .in_last   (s_pack_end),
        .push      (push),
        .push_data (push_data)
    );

    pve_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (status)
    );

    pve_output u_output (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_data      (head_data),
        .status         (status),
        .pop            (pop),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_payload_byte (m_payload_byte),
        .m_byte_valid   (m_byte_valid),
        .m_frame_done   (m_frame_done),
        .m_frame_bytes  (m_frame_bytes)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/pve_checker.sv
// Port-level checks for the extractor, bound to the top level.
`default_nettype none

module pve_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [pve_pkg::BYTE_W-1:0]    m_payload_byte,
    input wire logic                          m_byte_valid,
    input wire logic                          m_frame_done,
    input wire logic [pve_pkg::FRAME_W-1:0]   m_frame_bytes
);
    import pve_pkg::*;

    // Empty output after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set right after reset");

    // Hold a stalled beat.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte) && $stable(m_byte_valid)
            && $stable(m_frame_done) && $stable(m_frame_bytes))
        else $error("stalled result beat changed");

    // Every beat carries a payload byte or a frame report.
    a_beat_useful: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_byte_valid || m_frame_done)
        else $error("empty result beat");

    // Frame report carries a nonzero count; otherwise the count reads zero.
    a_frame_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_done == (m_frame_bytes != '0)))
        else $error("frame_bytes does not match frame_done");

    // Unused payload byte reads zero.
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_payload_byte == '0)
        else $error("payload_byte nonzero without byte_valid");

endmodule

bind ps_video_payload_extractor_top pve_checker u_pve_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_payload_byte (m_payload_byte),
    .m_byte_valid   (m_byte_valid),
    .m_frame_done   (m_frame_done),
    .m_frame_bytes  (m_frame_bytes)
);

`default_nettype wire
